// ===== sv/pkcs7pu_pkg.sv =====
package pkcs7pu_pkg;

  // One input item as it arrives on the stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_last;
    logic       pad_error;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // take the input item, update the ring and the counters
    logic push_byte;   // emit the result of a data byte
    logic pad_init;    // start emitting padding bytes
    logic push_pad;    // emit one padding byte
    logic rd_pad;      // read the last ring entry
    logic get_pad;     // latch the pad byte and its first checks
    logic scan_rd;     // read one pad entry
    logic scan_cmp;    // compare one pad entry
    logic emit_init;   // work out how many held bytes leave
    logic emit_rd;     // read one held byte
    logic emit_push;   // emit one held byte
    logic push_empty;  // emit an empty closing result
    logic clear_msg;   // message done, clear the counters
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic in_has;      // has_byte of the item on the input port
    logic in_eom;      // end_of_message of the item on the input port
    logic item_eom;    // end_of_message of the item being worked on
    logic direction;   // 0 pads, 1 strips
    logic need_byte;   // the data byte gives a result
    logic pad_last;    // current padding byte is the last one
    logic pad_valid;   // pad byte passes the range and length checks
    logic scan_last;   // current pad entry is the last ring entry
    logic keep_zero;   // no held byte leaves
    logic emit_last;   // current held byte is the last one
  } status_t;

endpackage

// ===== sv/pkcs7pu_dp.sv =====
module pkcs7pu_dp #(
  parameter int BLOCK_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pkcs7pu_pkg::in_item_t in_item,
  output pkcs7pu_pkg::out_item_t out_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  input  pkcs7pu_pkg::cmd_t     cmd,
  output pkcs7pu_pkg::status_t  status
);
  import pkcs7pu_pkg::*;

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(BLOCK_BYTES - 1);
  localparam logic [CW-1:0] BLOCK_CNT = CW'(BLOCK_BYTES);
  localparam logic [8:0]    BLOCK_W9  = 9'(BLOCK_BYTES);
  localparam logic [CW:0]   BLOCK_CW1 = (CW + 1)'(BLOCK_BYTES);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  // Held block ring; its contents are only used after being written.
  logic [7:0]    ring_mem [BLOCK_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] raddr;
  logic          re;

  logic          dir_r, dir_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic          seen_r, seen_nxt;
  logic          mis_r, mis_nxt;
  logic          item_eom_r;
  logic [7:0]    item_data_r;
  logic          need_byte_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    pad_r;
  logic          ok_r, ok_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          out_free;
  logic [CW-1:0] pad_len;
  logic          pad_valid;
  logic [8:0]    pad_first;
  logic [CW:0]   addr_sum;
  logic          push;

  // Configuration register.
  always_comb begin
    dir_nxt = dir_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0)) begin
      dir_nxt = cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, dir_r} : 32'd0;

  // Padding length and the pad byte checks.
  assign pad_len   = BLOCK_CNT - CW'(fill_r);
  assign pad_valid = seen_r && !mis_r && (rdata_r != 8'd0)
                     && ({1'b0, rdata_r} <= BLOCK_W9);
  // First ring slot covered by the pad byte.
  assign pad_first = BLOCK_W9 - {1'b0, rdata_r};

  // Ring address of the next held byte, wrapped once around the block.
  always_comb begin
    addr_sum = (CW + 1)'(start_r) + (CW + 1)'(cnt_r);
    if (addr_sum >= BLOCK_CW1) begin
      addr_sum = addr_sum - BLOCK_CW1;
    end
  end

  // Ring read address.
  always_comb begin
    raddr = fill_r;
    if (cmd.rd_pad) begin
      raddr = LAST_SLOT;
    end else if (cmd.scan_rd) begin
      raddr = idx_r;
    end else if (cmd.emit_rd) begin
      raddr = addr_sum[AW-1:0];
    end
  end

  assign re = cmd.accept || cmd.rd_pad || cmd.scan_rd || cmd.emit_rd;

  // Ring storage: read first, then write at the same slot.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= ring_mem[raddr];
    end
    if (cmd.accept && in_item.has_byte) begin
      ring_mem[fill_r] <= in_item.data_byte;
    end
  end

  // Message counters.
  always_comb begin
    fill_nxt = fill_r;
    seen_nxt = seen_r;
    mis_nxt  = mis_r;
    if (cmd.clear_msg) begin
      fill_nxt = '0;
      seen_nxt = 1'b0;
      mis_nxt  = 1'b0;
    end else if (cmd.accept && in_item.has_byte) begin
      if (fill_r == LAST_SLOT) begin
        fill_nxt = '0;
        seen_nxt = 1'b1;
        mis_nxt  = 1'b0;
      end else begin
        fill_nxt = fill_r + AW'(1);
        mis_nxt  = 1'b1;
      end
    end
  end

  // End-of-message sequencing registers.
  always_comb begin
    cnt_nxt   = cnt_r;
    ok_nxt    = ok_r;
    idx_nxt   = idx_r;
    keep_nxt  = keep_r;
    start_nxt = start_r;
    if (cmd.pad_init || cmd.emit_init) begin
      cnt_nxt = '0;
    end else if (cmd.push_pad || cmd.emit_push) begin
      cnt_nxt = cnt_r + ONE_CNT;
    end
    if (cmd.get_pad) begin
      ok_nxt  = pad_valid;
      idx_nxt = pad_first[AW-1:0];
    end
    if (cmd.scan_cmp) begin
      if (rdata_r != pad_r) begin
        ok_nxt = 1'b0;
      end
      idx_nxt = idx_r + AW'(1);
    end
    if (cmd.emit_init) begin
      if (ok_r) begin
        keep_nxt = CW'(BLOCK_W9 - {1'b0, pad_r});
      end else if (seen_r) begin
        keep_nxt = BLOCK_CNT;
      end else begin
        keep_nxt = CW'(fill_r);
      end
      start_nxt = seen_r ? fill_r : '0;
    end
  end

  // Output register.
  assign out_free = !out_valid_r || !out_stall;
  assign push = cmd.push_byte || cmd.push_pad || cmd.emit_push || cmd.push_empty;

  always_comb begin
    out_item_nxt = out_item_r;
    if (cmd.push_byte) begin
      out_item_nxt.out_byte     = dir_r ? rdata_r : item_data_r;
      out_item_nxt.out_has_byte = 1'b1;
      out_item_nxt.out_last     = 1'b0;
      out_item_nxt.pad_error    = 1'b0;
    end else if (cmd.push_pad) begin
      out_item_nxt.out_byte     = 8'(pad_len);
      out_item_nxt.out_has_byte = 1'b1;
      out_item_nxt.out_last     = status.pad_last;
      out_item_nxt.pad_error    = 1'b0;
    end else if (cmd.emit_push) begin
      out_item_nxt.out_byte     = rdata_r;
      out_item_nxt.out_has_byte = 1'b1;
      out_item_nxt.out_last     = status.emit_last;
      out_item_nxt.pad_error    = status.emit_last && !ok_r;
    end else if (cmd.push_empty) begin
      out_item_nxt.out_byte     = 8'd0;
      out_item_nxt.out_has_byte = 1'b0;
      out_item_nxt.out_last     = 1'b1;
      out_item_nxt.pad_error    = !ok_r;
    end
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      fill_r      <= '0;
      seen_r      <= 1'b0;
      mis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dir_r       <= dir_nxt;
      fill_r      <= fill_nxt;
      seen_r      <= seen_nxt;
      mis_r       <= mis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_data_r <= in_item.data_byte;
      item_eom_r  <= in_item.end_of_message;
      need_byte_r <= !dir_r || seen_r;
    end
    if (cmd.get_pad) begin
      pad_r <= rdata_r;
    end
    cnt_r      <= cnt_nxt;
    ok_r       <= ok_nxt;
    idx_r      <= idx_nxt;
    keep_r     <= keep_nxt;
    start_r    <= start_nxt;
    out_item_r <= out_item_nxt;
  end

  // Status to the controller.
  always_comb begin
    status.out_free  = out_free;
    status.in_has    = in_item.has_byte;
    status.in_eom    = in_item.end_of_message;
    status.item_eom  = item_eom_r;
    status.direction = dir_r;
    status.need_byte = need_byte_r;
    status.pad_last  = (cnt_r == pad_len - ONE_CNT);
    status.pad_valid = pad_valid;
    status.scan_last = (idx_r == LAST_SLOT);
    status.keep_zero = (keep_nxt == '0);
    status.emit_last = (cnt_r == keep_r - ONE_CNT);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/pkcs7pu_ctrl.sv =====
module pkcs7pu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output pkcs7pu_pkg::cmd_t    cmd,
  input  pkcs7pu_pkg::status_t status
);
  import pkcs7pu_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_BYTE    = 4'd1;
  localparam logic [3:0] S_END     = 4'd2;
  localparam logic [3:0] S_PAD     = 4'd3;
  localparam logic [3:0] S_GETPAD  = 4'd4;
  localparam logic [3:0] S_SCANRD  = 4'd5;
  localparam logic [3:0] S_SCANCMP = 4'd6;
  localparam logic [3:0] S_EINIT   = 4'd7;
  localparam logic [3:0] S_EEMPTY  = 4'd8;
  localparam logic [3:0] S_ERD     = 4'd9;
  localparam logic [3:0] S_EPUSH   = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.in_has) begin
            state_nxt = S_BYTE;
          end else if (status.in_eom) begin
            state_nxt = S_END;
          end
        end
      end
      S_BYTE: begin
        if (!status.need_byte || status.out_free) begin
          cmd.push_byte = status.need_byte;
          state_nxt     = status.item_eom ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (status.direction) begin
          cmd.rd_pad = 1'b1;
          state_nxt  = S_GETPAD;
        end else begin
          cmd.pad_init = 1'b1;
          state_nxt    = S_PAD;
        end
      end
      S_PAD: begin
        if (status.out_free) begin
          cmd.push_pad = 1'b1;
          if (status.pad_last) begin
            cmd.clear_msg = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_GETPAD: begin
        cmd.get_pad = 1'b1;
        state_nxt   = status.pad_valid ? S_SCANRD : S_EINIT;
      end
      S_SCANRD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCANCMP;
      end
      S_SCANCMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = status.scan_last ? S_EINIT : S_SCANRD;
      end
      S_EINIT: begin
        cmd.emit_init = 1'b1;
        state_nxt     = status.keep_zero ? S_EEMPTY : S_ERD;
      end
      S_EEMPTY: begin
        if (status.out_free) begin
          cmd.push_empty = 1'b1;
          cmd.clear_msg  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EPUSH;
      end
      S_EPUSH: begin
        if (status.out_free) begin
          cmd.emit_push = 1'b1;
          if (status.emit_last) begin
            cmd.clear_msg = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/pkcs7_pad_unpad_stream.sv =====
// Data byte item: accepted while idle; its result is pushed to the output register once
// that is free, and then the next item is taken. After the closing item, pad end emits
// each padding byte; unpad end reads the last ring entry as the pad byte, reads and
// checks each covered pad byte, then reads and pushes each kept byte (or an empty close)
// through the single ring read port; output stalls hold the pushes. rst_n is synchronous
// and active low; it clears the direction, message counters, state machine and output
// valid; the ring keeps its contents, which are always written before use.
module pkcs7_pad_unpad_stream #(
  parameter int BLOCK_BYTES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pkcs7pu_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pkcs7pu_pkg::out_item_t out_item,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import pkcs7pu_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_pready = 1'b1;

  // Sequencer for one item and the message end.
  pkcs7pu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Ring, counters, checks and output register.
  pkcs7pu_dp #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .out_item    (out_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
